/* src/ksmp_pkg.sv */
package ksmp_pkg;

	// input word fields, lowest bit first
	localparam int OPC_W = 2;
	localparam int ROW_W = 7;
	localparam int COL_W = 6;
	localparam int VAL_W = 32;

	localparam int OPC_LSB = 0;
	localparam int ROW_LSB = OPC_LSB + OPC_W;
	localparam int COL_LSB = ROW_LSB + ROW_W;
	localparam int VAL_LSB = COL_LSB + COL_W;
	localparam int IN_TDATA_W = 48;

	// output word fields
	localparam int RES_LSB = 0;
	localparam int STS_LSB = RES_LSB + VAL_W;
	localparam int OUT_TDATA_W = 40;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam int FRAC_BITS = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIM_P       = 2'd0,
		REG_FACTOR_RANK = 2'd1,
		REG_NUM_COLUMNS = 2'd2,
		REG_ORDER_MODE  = 2'd3
	} reg_idx_t;

	typedef enum logic [OPC_W-1:0] {
		OP_WR_FACTOR = 2'd0,
		OP_WR_DATA   = 2'd1,
		OP_RD_OUT    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_RD,
		ST_DRAIN,
		ST_OUT
	} state_t;

endpackage

/* src/ksmp_div.sv */
// Restoring divider, one quotient bit per cycle. The quotient must fit in QW bits.
module ksmp_div #(
	parameter int NW = 7,
	parameter int DW = 4,
	parameter int QW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [QW-1:0] quot,
	output logic [QW-1:0] rem
);

	localparam int SW = NW + DW + QW;
	localparam int CW = (QW > 1) ? $clog2(QW) : 1;

	logic [SW-1:0] rem_q;
	logic [QW-1:0] quot_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] trial;
	logic          ge;

	assign trial = SW'(dvs_q) << cnt_q;
	assign ge    = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= SW'(dividend);
			dvs_q  <= divisor;
			quot_q <= '0;
			cnt_q  <= CW'(QW - 1);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - trial;
			end
			quot_q[cnt_q] <= ge;
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q[QW-1:0];

endmodule

/* src/kronecker_structured_matrix_product_top.sv */
// channel   | dir | handshake                      | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | opcode, row_index, col_index, value
// m_axis    | out | m_axis_tvalid / m_axis_tready  | result_value, status
// cfg       | in  | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// Writes can stream back to back.
// An in-range read passes through the 3-step row decode divider and its done strobe, a
// setup state, p factor/data memory read pairs, the multiply-accumulate drain and the
// output state before its result loads. Row 0 reads skip the divider and setup and
// issue one read pair; out-of-range reads go straight to the output state. The next
// word is accepted the cycle after the result loads; the output register lets it in
// while that result waits. Reset clears control and configuration registers only.
module kronecker_structured_matrix_product_top #(
	parameter int MAX_P    = 8,
	parameter int MAX_RANK = 8,
	parameter int MAX_COLS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [1:0] opcode, [8:2] row_index, [14:9] col_index, [46:15] value
	input  logic [ksmp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] result_value, [32] status
	output logic [ksmp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ksmp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ksmp_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ksmp_pkg::*;

	localparam int PW     = $clog2(MAX_P + 1);
	localparam int RKW    = $clog2(MAX_RANK + 1);
	localparam int NCW    = $clog2(MAX_COLS + 1);
	localparam int DVW    = (PW > RKW) ? PW : RKW;
	localparam int QMAX   = (MAX_P > MAX_RANK) ? MAX_P : MAX_RANK;
	localparam int QW     = (QMAX > 1) ? $clog2(QMAX) : 1;
	localparam int FDEPTH = MAX_P * MAX_RANK;
	localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
	localparam int DROWS  = 1 + MAX_P * MAX_P;
	localparam int DRW    = $clog2(DROWS);
	localparam int DDEPTH = DROWS * MAX_COLS;
	localparam int DAW    = $clog2(DDEPTH);
	localparam int CMPW   = ((ROW_W > PW + DVW) ? ROW_W : PW + DVW) + 1;
	localparam int CCW    = ((COL_W > NCW) ? COL_W : NCW) + 1;
	localparam int AW     = 2 * VAL_W + ((MAX_P > 1) ? $clog2(MAX_P) : 0) + 1;
	localparam int PADW   = OUT_TDATA_W - VAL_W - 1;

	// input word fields
	logic [OPC_W-1:0]        in_op;
	logic [ROW_W-1:0]        in_row;
	logic [COL_W-1:0]        in_col;
	logic signed [VAL_W-1:0] in_val;

	assign in_op  = s_axis_tdata[OPC_LSB +: OPC_W];
	assign in_row = s_axis_tdata[ROW_LSB +: ROW_W];
	assign in_col = s_axis_tdata[COL_LSB +: COL_W];
	assign in_val = s_axis_tdata[VAL_LSB +: VAL_W];

	// configuration
	logic [PW-1:0]  dim_p_q;
	logic [RKW-1:0] factor_rank_q;
	logic [NCW-1:0] num_columns_q;
	logic           order_mode_q;
	logic [PW-1:0]  cfg_p;
	logic [RKW-1:0] cfg_rank;
	logic [NCW-1:0] cfg_ncol;

	always_comb begin
		if (cfg_data[3:0] == 4'd0) begin
			cfg_p = PW'(1);
		end else if (int'(cfg_data[3:0]) > MAX_P) begin
			cfg_p = PW'(MAX_P);
		end else begin
			cfg_p = PW'(cfg_data[3:0]);
		end
		if (cfg_data[3:0] == 4'd0) begin
			cfg_rank = RKW'(1);
		end else if (int'(cfg_data[3:0]) > MAX_RANK) begin
			cfg_rank = RKW'(MAX_RANK);
		end else begin
			cfg_rank = RKW'(cfg_data[3:0]);
		end
		if (cfg_data[6:0] == 7'd0) begin
			cfg_ncol = NCW'(1);
		end else if (int'(cfg_data[6:0]) > MAX_COLS) begin
			cfg_ncol = NCW'(MAX_COLS);
		end else begin
			cfg_ncol = NCW'(cfg_data[6:0]);
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_p_q       <= PW'(1);
			factor_rank_q <= RKW'(1);
			num_columns_q <= NCW'(1);
			order_mode_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIM_P:       dim_p_q       <= cfg_p;
				REG_FACTOR_RANK: factor_rank_q <= cfg_rank;
				REG_NUM_COLUMNS: num_columns_q <= cfg_ncol;
				REG_ORDER_MODE:  order_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// range checks
	logic [CMPW-1:0] rd_row_lim;
	logic [CMPW-1:0] wr_row_lim;
	logic            rd_ok;
	logic            wf_ok;
	logic            wd_ok;
	logic            col_in_use;

	assign rd_row_lim = CMPW'(dim_p_q) * CMPW'(factor_rank_q) + CMPW'(1);
	assign wr_row_lim = CMPW'(dim_p_q) * CMPW'(dim_p_q) + CMPW'(1);
	assign col_in_use = CCW'(in_col) < CCW'(num_columns_q);
	assign rd_ok      = (CMPW'(in_row) < rd_row_lim) && col_in_use;
	assign wd_ok      = (CMPW'(in_row) < wr_row_lim) && col_in_use;
	assign wf_ok      = (CMPW'(in_row) < CMPW'(dim_p_q)) &&
	                    (CMPW'(in_col) < CMPW'(factor_rank_q));

	// control
	state_t state_q, state_d;
	logic   in_acc;
	logic   rd_issue;
	logic   div_start;
	logic   out_load;
	logic   f_we;
	logic   d_we;
	logic   div_done;
	logic   v_s1, v_s2;
	logic   m_valid_q;
	logic   row0_q;
	logic   err_q;
	logic   k_last;

	logic [PW-1:0]  k_q;
	logic [QW-1:0]  r_q;
	logic [DRW-1:0] drow_q;
	logic [COL_W-1:0] col_q;
	logic [QW-1:0]  div_quot;
	logic [QW-1:0]  div_rem;
	logic [DVW-1:0] div_dvs;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign k_last = PW'(k_q + PW'(1)) == dim_p_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (in_op == OP_RD_OUT)) begin
					if (!rd_ok) begin
						state_d = ST_OUT;
					end else if (in_row == '0) begin
						state_d = ST_RD;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: state_d = ST_RD;
			ST_RD: begin
				if (row0_q || k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		rd_issue      = (state_q == ST_RD);
		out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
		div_start     = in_acc && (in_op == OP_RD_OUT) && rd_ok && (in_row != '0);
		f_we          = in_acc && (in_op == OP_WR_FACTOR) && wf_ok;
		d_we          = in_acc && (in_op == OP_WR_DATA) && wd_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= rd_issue;
			v_s2    <= v_s1;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// row decode: mode 0 splits row-1 by p, mode 1 by rank
	assign div_dvs = order_mode_q ? DVW'(factor_rank_q) : DVW'(dim_p_q);

	ksmp_div #(
		.NW(ROW_W),
		.DW(DVW),
		.QW(QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_row - ROW_W'(1)),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	logic [QW-1:0] blk_i;
	assign blk_i = order_mode_q ? div_quot : div_rem;

	always_ff @(posedge clk) begin
		if (in_acc && (in_op == OP_RD_OUT)) begin
			col_q  <= in_col;
			row0_q <= (in_row == '0);
			err_q  <= !rd_ok;
			k_q    <= '0;
			r_q    <= '0;
			drow_q <= '0;
		end else if (state_q == ST_SETUP) begin
			r_q    <= order_mode_q ? div_rem : div_quot;
			drow_q <= DRW'(1 + int'(blk_i) * int'(dim_p_q));
		end else if (rd_issue) begin
			k_q    <= k_q + PW'(1);
			drow_q <= drow_q + DRW'(1);
		end
	end

	// stores
	logic signed [VAL_W-1:0] fmem [FDEPTH];
	logic signed [VAL_W-1:0] dmem [DDEPTH];
	logic [FAW-1:0]          f_wa, f_ra;
	logic [DAW-1:0]          d_wa, d_ra;
	logic signed [VAL_W-1:0] f_rd_s1, d_rd_s1;

	assign f_wa = FAW'(int'(in_row) * MAX_RANK + int'(in_col));
	assign d_wa = DAW'(int'(in_row) * MAX_COLS + int'(in_col));
	assign f_ra = FAW'(int'(k_q) * MAX_RANK + int'(r_q));
	assign d_ra = DAW'(int'(drow_q) * MAX_COLS + int'(col_q));

	always_ff @(posedge clk) begin
		if (f_we) begin
			fmem[f_wa] <= in_val;
		end
		if (rd_issue) begin
			f_rd_s1 <= fmem[f_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			dmem[d_wa] <= in_val;
		end
		if (rd_issue) begin
			d_rd_s1 <= dmem[d_ra];
		end
	end

	// multiply-accumulate, exact
	logic signed [2*VAL_W-1:0] prod_s2;
	logic signed [AW-1:0]      acc_q;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= f_rd_s1 * d_rd_s1;
		end
		if (in_acc) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + AW'(prod_s2);
		end
	end

	// floor shift then saturate
	logic signed [AW-1:0]    acc_sh;
	logic [AW-VAL_W:0]       acc_top;
	logic signed [VAL_W-1:0] sat_val;
	logic signed [VAL_W-1:0] res_val;

	assign acc_sh  = acc_q >>> FRAC_BITS;
	assign acc_top = acc_sh[AW-1:VAL_W-1];

	always_comb begin
		if ((&acc_top) || !(|acc_top)) begin
			sat_val = acc_sh[VAL_W-1:0];
		end else if (acc_sh[AW-1]) begin
			sat_val = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(VAL_W-1){1'b1}}};
		end
		if (err_q) begin
			res_val = '0;
		end else if (row0_q) begin
			res_val = d_rd_s1;
		end else begin
			res_val = sat_val;
		end
	end

	logic [OUT_TDATA_W-1:0] m_data_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {{PADW{1'b0}}, err_q, res_val};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

/* src/ksmp_checker.sv */
module ksmp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [ksmp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [ksmp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import ksmp_pkg::*;

	logic [OPC_W-1:0] op;
	assign op = s_axis_tdata[OPC_LSB +: OPC_W];

	// store writes never stall the input
	a_wr_stream: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (op == OP_WR_FACTOR || op == OP_WR_DATA)
		|=> s_axis_tready)
		else $error("input stalled after a store write");

	// a read word takes the engine, so input ready is low in the cycle after it
	a_rd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (op == OP_RD_OUT) |=> !s_axis_tready)
		else $error("input ready right after a read word");

	// error status carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[STS_LSB] |-> (m_axis_tdata[VAL_W-1:0] == '0))
		else $error("nonzero value with error status");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:STS_LSB+1] == '0))
		else $error("output padding not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

endmodule

bind kronecker_structured_matrix_product_top ksmp_checker u_ksmp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
